[hdl/ipuc_pkg.sv]
// ----------------------------------------------------------------------------
// ipuc_pkg: shared types and helpers for the IPv4/UDP checksum fixup
// Status codes, the item and finish records passed between stages, and the
// ones'-complement add used by both datapath stages and the final fold.
// ----------------------------------------------------------------------------
`default_nettype none

package ipuc_pkg;

  localparam logic [15:0] SUM_MASK16    = 16'hffff;
  localparam logic [15:0] POS_MAX       = 16'hffff;
  localparam logic [16:0] COUNT_MAX     = 17'h1ffff;
  localparam logic [3:0]  IHL_MIN       = 4'd5;
  localparam logic [17:0] UDP_HDR_BYTES = 18'd8;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] word;
    logic        odd_byte;
    logic        last;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] total;
    logic [15:0] ulen;
    logic [31:0] ip_sum;
    logic [31:0] udp_sum;
  } fin_t;

  // 32-bit add with end-around carry.
  function automatic logic [31:0] sum_add(input logic [31:0] acc, input logic [31:0] v);
    logic [32:0] s;
    s = {1'b0, acc} + {1'b0, v};
    return s[31:0] + {31'd0, s[32]};
  endfunction

  // Two folds to 16 bits, then complement.
  function automatic logic [15:0] sum_fold(input logic [31:0] acc);
    logic [16:0] a;
    logic [16:0] b;
    a = {1'b0, acc[15:0]} + {1'b0, acc[31:16]};
    b = {1'b0, a[15:0]} + {16'd0, a[16]};
    return ~b[15:0];
  endfunction

endpackage

`default_nettype wire

[hdl/ipuc_accum.sv]
// ----------------------------------------------------------------------------
// ipuc_accum: per-word accumulation stage
// Tracks the word position, the header length and both running sums, and on
// the last word of a packet captures the finish record for the fold stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ipuc_accum
  import ipuc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  item_valid,
  input  wire item_t item,
  output logic       item_ready,
  output logic       fin_valid,
  output fin_t       fin,
  input  wire logic  fin_ready
);

  localparam logic [15:0] POS_TOT_LEN  = 16'd1;
  localparam logic [15:0] POS_PROTO    = 16'd4;
  localparam logic [15:0] POS_HDR_CSUM = 16'd5;
  localparam logic [15:0] POS_SRC_ADDR = 16'd6;
  localparam logic [15:0] POS_DST_END  = 16'd9;
  localparam logic [15:0] UDP_SUM_WORDS = 16'd2;

  logic [15:0] pos_r, pos_nxt;
  logic [3:0]  hw_r;
  logic [31:0] ip_sum_r, ip_sum_nxt;
  logic [31:0] udp_sum_r, udp_sum_nxt;
  logic [16:0] pbc_r, pbc_nxt;
  logic        fin_valid_r;
  fin_t        fin_r, fin_nxt;

  logic        odd;
  logic [15:0] w;
  logic [3:0]  ihl_cur;
  logic [15:0] hip, hip_p3, hip_p4, q;
  logic        in_ip, in_udph, in_pay;
  logic        ip_add, udp_add;
  logic [15:0] udp_val;
  logic [17:0] pbc_inc, total18, ulen18;
  logic        short_pkt, long_pkt;
  logic        fire;

  always_comb begin
    odd     = item.last & item.odd_byte;
    w       = odd ? {item.word[15:8], 8'h00} : item.word;
    if (pos_r == 16'd0) begin
      ihl_cur = (w[11:8] < IHL_MIN) ? IHL_MIN : w[11:8];
    end else begin
      ihl_cur = hw_r;
    end
    hip     = {11'd0, ihl_cur, 1'b0};
    hip_p3  = hip + 16'd3;
    hip_p4  = hip + 16'd4;
    q       = pos_r - hip;
    in_ip   = pos_r < hip;
    in_udph = !in_ip && (pos_r < hip_p4);
    in_pay  = !in_ip && !in_udph;

    ip_add  = in_ip && (pos_r != POS_TOT_LEN) && (pos_r != POS_HDR_CSUM);
    udp_add = 1'b0;
    udp_val = w;
    if (in_ip && pos_r == POS_PROTO) begin
      udp_add = 1'b1;
      udp_val = {8'h00, w[7:0]};
    end else if (in_ip && pos_r >= POS_SRC_ADDR && pos_r <= POS_DST_END) begin
      udp_add = 1'b1;
    end else if (in_udph && q < UDP_SUM_WORDS) begin
      udp_add = 1'b1;
    end else if (in_pay) begin
      udp_add = 1'b1;
    end

    ip_sum_nxt  = ip_add ? sum_add(ip_sum_r, {16'd0, w}) : ip_sum_r;
    udp_sum_nxt = udp_add ? sum_add(udp_sum_r, {16'd0, udp_val}) : udp_sum_r;

    pbc_inc = {1'b0, pbc_r} + (odd ? 18'd1 : 18'd2);
    if (!in_pay) begin
      pbc_nxt = pbc_r;
    end else if (pbc_inc > {1'b0, COUNT_MAX}) begin
      pbc_nxt = COUNT_MAX;
    end else begin
      pbc_nxt = pbc_inc[16:0];
    end

    pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + 16'd1;
    total18   = {12'd0, ihl_cur, 2'b00} + UDP_HDR_BYTES + {1'b0, pbc_nxt};
    ulen18    = UDP_HDR_BYTES + {1'b0, pbc_nxt};
    short_pkt = (pos_r < hip_p3) || ((pos_r == hip_p3) && odd);
    long_pkt  = total18 > {2'b00, SUM_MASK16};

    if (short_pkt) begin
      fin_nxt.status = ST_SHORT;
    end else if (long_pkt) begin
      fin_nxt.status = ST_LONG;
    end else begin
      fin_nxt.status = ST_OK;
    end
    fin_nxt.total   = total18[15:0];
    fin_nxt.ulen    = ulen18[15:0];
    fin_nxt.ip_sum  = ip_sum_nxt;
    fin_nxt.udp_sum = udp_sum_nxt;
  end

  assign item_ready = !item.last || !fin_valid_r || fin_ready;
  assign fire       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hw_r        <= '0;
      ip_sum_r    <= '0;
      udp_sum_r   <= '0;
      pbc_r       <= '0;
      fin_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        if (item.last) begin
          pos_r     <= '0;
          hw_r      <= '0;
          ip_sum_r  <= '0;
          udp_sum_r <= '0;
          pbc_r     <= '0;
        end else begin
          pos_r     <= pos_nxt;
          hw_r      <= ihl_cur;
          ip_sum_r  <= ip_sum_nxt;
          udp_sum_r <= udp_sum_nxt;
          pbc_r     <= pbc_nxt;
        end
      end
      if (fire && item.last) begin
        fin_valid_r <= 1'b1;
      end else if (fin_ready) begin
        fin_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item.last) begin
      fin_r <= fin_nxt;
    end
  end

  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;

endmodule

`default_nettype wire

[hdl/ipuc_finish.sv]
// ----------------------------------------------------------------------------
// ipuc_finish: checksum fold and result register
// Adds the recomputed lengths into both sums, folds them to 16 bits and
// holds the result item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipuc_finish
  import ipuc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fin_valid,
  input  wire fin_t  fin,
  output logic       fin_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_ip_total_length,
  output logic [15:0] out_ip_header_checksum,
  output logic [15:0] out_udp_length,
  output logic [15:0] out_udp_checksum
);

  logic        out_valid_r;
  status_t     status_r;
  logic [15:0] total_r, ipc_r, ulen_r, udpc_r;

  logic [31:0] ip_tot, udp_one, udp_two;
  logic [15:0] ipc, udpc_raw, udpc;
  logic        ok;

  always_comb begin
    ip_tot   = sum_add(fin.ip_sum, {16'd0, fin.total});
    ipc      = sum_fold(ip_tot);
    udp_one  = sum_add(fin.udp_sum, {16'd0, fin.ulen});
    udp_two  = sum_add(udp_one, {16'd0, fin.ulen});
    udpc_raw = sum_fold(udp_two);
    udpc     = (udpc_raw == 16'd0) ? SUM_MASK16 : udpc_raw;
    ok       = (fin.status == ST_OK);
  end

  assign fin_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      status_r <= fin.status;
      total_r  <= ok ? fin.total : 16'd0;
      ipc_r    <= ok ? ipc : 16'd0;
      ulen_r   <= ok ? fin.ulen : 16'd0;
      udpc_r   <= ok ? udpc : 16'd0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_ip_total_length    = total_r;
  assign out_ip_header_checksum = ipc_r;
  assign out_udp_length         = ulen_r;
  assign out_udp_checksum       = udpc_r;

endmodule

`default_nettype wire

[hdl/ipv4_udp_checksum_fixup.sv]
// ----------------------------------------------------------------------------
// ipv4_udp_checksum_fixup: IPv4/UDP length and checksum recompute
// The in_ channel carries one 16-bit big-endian packet word per item: the
// IPv4 header, the UDP header, then payload, with in_last on the final word
// and in_odd_byte when that word holds only its high byte. For each packet
// one result item appears on the out_ channel: status, the IPv4 total
// length and header checksum, and the UDP length and checksum. Words that
// are not last produce no result.
// Unless stalled, the block takes one word per cycle with no gaps, packets back to back.
// A result becomes valid once its last word has passed through the input
// register, the finish register of the accumulation stage and the result
// register of the fold stage.
// While a result waits on out_ready, further non-last words are still
// taken; a last word waits only when both the finish register and the
// output register are full, and the words behind it wait with it.
// Synchronous reset clears all sums, counters and valid flags, so the next
// word accepted is taken as the first word of a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_udp_checksum_fixup
  import ipuc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_word,
  input  wire logic        in_odd_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_ip_total_length,
  output logic [15:0]      out_ip_header_checksum,
  output logic [15:0]      out_udp_length,
  output logic [15:0]      out_udp_checksum
);

  logic  s0_valid_r;
  item_t s0_item_r;
  logic  acc_ready;
  logic  fin_valid;
  logic  fin_ready;
  fin_t  fin;

  assign in_ready = !s0_valid_r || acc_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item_r.word     <= in_word;
      s0_item_r.odd_byte <= in_odd_byte;
      s0_item_r.last     <= in_last;
    end
  end

  ipuc_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s0_valid_r),
    .item       (s0_item_r),
    .item_ready (acc_ready),
    .fin_valid  (fin_valid),
    .fin        (fin),
    .fin_ready  (fin_ready)
  );

  ipuc_finish u_finish (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .fin_valid              (fin_valid),
    .fin                    (fin),
    .fin_ready              (fin_ready),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_ip_total_length    (out_ip_total_length),
    .out_ip_header_checksum (out_ip_header_checksum),
    .out_udp_length         (out_udp_length),
    .out_udp_checksum       (out_udp_checksum)
  );

endmodule

`default_nettype wire

[hdl/ipuc_checker.sv]
// ----------------------------------------------------------------------------
// ipuc_checker: port-level checks for the checksum fixup
// Watches the top-level ports for result consistency and output behavior,
// and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ipuc_checker
  import ipuc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_ip_total_length,
  input wire logic [15:0] out_ip_header_checksum,
  input wire logic [15:0] out_udp_length,
  input wire logic [15:0] out_udp_checksum
);

  logic [16:0] hdr_gap;
  assign hdr_gap = {1'b0, out_ip_total_length} - {1'b0, out_udp_length};

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_udp_checksum) && $stable(out_ip_header_checksum))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SHORT || out_status == ST_LONG) |->
      out_ip_total_length == 16'd0 && out_ip_header_checksum == 16'd0
      && out_udp_length == 16'd0 && out_udp_checksum == 16'd0)
    else $error("error result carries nonzero fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_SHORT
      || out_status == ST_LONG)
    else $error("undefined status code");

  a_ok_lengths: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_udp_checksum != 16'd0
      && out_udp_length >= 16'd8 && hdr_gap >= 17'd20 && hdr_gap <= 17'd60
      && hdr_gap[1:0] == 2'b00)
    else $error("inconsistent lengths or zero UDP checksum");

endmodule

bind ipv4_udp_checksum_fixup ipuc_checker u_ipuc_checker (.*);

`default_nettype wire

[test/ipv4_udp_checksum_fixup_test.sv]
// ----------------------------------------------------------------------------
// ipv4_udp_checksum_fixup_test: self-checking bench for the checksum fixup
// Streams IPv4/UDP packets word by word through the block under bursty input
// and a stalling output. A scoreboard class tracks the packet state for every
// accepted item and checks each result against the oldest expected one. The
// packets include short, odd-length, optioned and long-payload cases.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_udp_checksum_fixup_test;
  import ipuc_pkg::*;

  localparam int ITEM_TARGET = 1550;
  localparam int MIN_PACKETS = 20;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  typedef struct {
    status_t     status;
    logic [15:0] total;
    logic [15:0] ip_csum;
    logic [15:0] ulen;
    logic [15:0] udp_csum;
  } fixup_result_t;

  class fixup_scoreboard;
    logic [15:0] pos;
    logic [3:0]  ihl_words;
    logic [31:0] ip_acc;
    logic [31:0] udp_acc;
    logic [16:0] payload_bytes;
    fixup_result_t pending_results[$];
    int errors;

    function new();
      clear_packet();
      errors = 0;
    endfunction

    function void clear_packet();
      pos = 16'd0;
      ihl_words = 4'd0;
      ip_acc = 32'd0;
      udp_acc = 32'd0;
      payload_bytes = 17'd0;
    endfunction

    function logic [31:0] ones_add(logic [31:0] acc, logic [31:0] v);
      logic [32:0] s;
      s = 33'(acc) + 33'(v);
      return s[31:0] + 32'(s[32]);
    endfunction

    function logic [15:0] fold_invert(logic [31:0] acc);
      logic [31:0] t;
      t = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
      return ~t[15:0];
    endfunction

    function void note_word(logic [15:0] word_in, logic odd_in, logic last_in);
      logic [15:0] w;
      logic odd;
      int p;
      int hip;
      int nbytes;
      int total;
      int ulen;
      fixup_result_t r;
      odd = last_in & odd_in;
      w = odd ? {word_in[15:8], 8'h00} : word_in;
      p = int'(pos);
      if (p == 0) begin
        ihl_words = (w[11:8] < 4'd5) ? 4'd5 : w[11:8];
      end
      hip = 2 * int'(ihl_words);
      if (p < hip) begin
        if (p != 1 && p != 5) begin
          ip_acc = ones_add(ip_acc, {16'd0, w});
        end
        if (p == 4) begin
          udp_acc = ones_add(udp_acc, {24'd0, w[7:0]});
        end
        if (p >= 6 && p <= 9) begin
          udp_acc = ones_add(udp_acc, {16'd0, w});
        end
      end else if (p < hip + 4) begin
        if (p - hip < 2) begin
          udp_acc = ones_add(udp_acc, {16'd0, w});
        end
      end else begin
        udp_acc = ones_add(udp_acc, {16'd0, w});
        nbytes = int'(payload_bytes) + (odd ? 1 : 2);
        if (nbytes > 'h1ffff) begin
          nbytes = 'h1ffff;
        end
        payload_bytes = 17'(nbytes);
      end
      if (pos != 16'hffff) begin
        pos = pos + 16'd1;
      end
      if (!last_in) begin
        return;
      end
      r.status = ST_OK;
      r.total = 16'd0;
      r.ip_csum = 16'd0;
      r.ulen = 16'd0;
      r.udp_csum = 16'd0;
      if (p < hip + 3 || (p == hip + 3 && odd)) begin
        r.status = ST_SHORT;
      end else begin
        total = 4 * int'(ihl_words) + 8 + int'(payload_bytes);
        if (total > 65535) begin
          r.status = ST_LONG;
        end else begin
          ulen = 8 + int'(payload_bytes);
          r.total = 16'(total);
          r.ulen = 16'(ulen);
          r.ip_csum = fold_invert(ones_add(ip_acc, 32'(total)));
          r.udp_csum = fold_invert(ones_add(ones_add(udp_acc, 32'(ulen)), 32'(ulen)));
          if (r.udp_csum == 16'd0) begin
            r.udp_csum = 16'hffff;
          end
        end
      end
      pending_results.push_back(r);
      clear_packet();
    endfunction

    function void compare_field(string field, logic [15:0] expected, logic [15:0] actual);
      if (expected !== actual) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, expected, actual);
      end
    endfunction

    function void check_result(logic [1:0] status, logic [15:0] total, logic [15:0] ip_csum,
                               logic [15:0] ulen, logic [15:0] udp_csum);
      fixup_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got status %0d total %h", $time,
                 status, total);
        return;
      end
      e = pending_results.pop_front();
      compare_field("status", {14'd0, e.status}, {14'd0, status});
      compare_field("ip_total_length", e.total, total);
      compare_field("ip_header_checksum", e.ip_csum, ip_csum);
      compare_field("udp_length", e.ulen, ulen);
      compare_field("udp_checksum", e.udp_csum, udp_csum);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_word = 16'd0;
  logic        in_odd_byte = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_ip_total_length;
  logic [15:0] out_ip_header_checksum;
  logic [15:0] out_udp_length;
  logic [15:0] out_udp_checksum;

  fixup_scoreboard sb = new();
  int burst_left = 0;
  int words_sent = 0;
  int packets_sent = 0;
  int idle_cycles = 0;
  int rx_tick = 0;
  int rx_mode = 0;
  int rx_period = 2;

  ipv4_udp_checksum_fixup u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_word                (in_word),
    .in_odd_byte            (in_odd_byte),
    .in_last                (in_last),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_ip_total_length    (out_ip_total_length),
    .out_ip_header_checksum (out_ip_header_checksum),
    .out_udp_length         (out_udp_length),
    .out_udp_checksum       (out_udp_checksum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_word(in_word, in_odd_byte, in_last);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_status, out_ip_total_length, out_ip_header_checksum,
                      out_udp_length, out_udp_checksum);
    end
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 256 == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_period <= $urandom_range(2, 7);
    end
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= (rx_tick % rx_period) == 0;
      end
      default: begin
        out_ready <= (rx_tick % 64) >= 24;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic [15:0] w, input logic odd, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_word <= w;
    in_odd_byte <= odd;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(0, 30);
    end
  endtask

  task automatic send_packet(input logic [15:0] pkt[$], input logic odd_tail);
    int last_idx;
    last_idx = pkt.size() - 1;
    foreach (pkt[i]) begin
      send_word(pkt[i], (i == last_idx) ? odd_tail : 1'($urandom_range(0, 3) == 0),
                i == last_idx);
    end
    packets_sent++;
  endtask

  task automatic build_packet(input logic [3:0] ihl_nib, input int n_words, input fill_t fill,
                              output logic [15:0] pkt[$]);
    pkt = {};
    for (int i = 0; i < n_words; i++) begin
      case (fill)
        FILL_ZERO: begin
          pkt.push_back(16'h0000);
        end
        FILL_ONES: begin
          pkt.push_back(16'hffff);
        end
        default: begin
          pkt.push_back(16'($urandom));
        end
      endcase
    end
    if (fill == FILL_RANDOM && n_words > 0) begin
      pkt[0][11:8] = ihl_nib;
      if ($urandom_range(0, 9) != 0) begin
        pkt[0][15:12] = 4'h4;
      end
    end
  endtask

  // The last payload word is chosen so that the computed UDP sum comes out as zero.
  task automatic cancel_udp_sum(inout logic [15:0] pkt[$]);
    fixup_scoreboard scratch;
    int last_idx;
    scratch = new();
    last_idx = pkt.size() - 1;
    pkt[last_idx] = 16'h0000;
    foreach (pkt[i]) begin
      scratch.note_word(pkt[i], 1'b0, i == last_idx);
    end
    if (scratch.pending_results[0].status == ST_OK) begin
      pkt[last_idx] = scratch.pending_results[0].udp_csum;
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic int header_span(int ihl);
    return ((ihl < 5) ? 5 : ihl) * 2 + 4;
  endfunction

  initial begin
    logic [15:0] pkt[$];
    int ihl;
    int hw;
    int n;
    int kind;
    logic odd_tail;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    build_packet(4'd5, 14, FILL_RANDOM, pkt);
    send_packet(pkt, 1'b0);
    build_packet(4'd5, 14, FILL_RANDOM, pkt);
    send_packet(pkt, 1'b1);
    build_packet(4'd5, 1, FILL_RANDOM, pkt);
    send_packet(pkt, 1'b0);
    build_packet(4'd5, 13, FILL_RANDOM, pkt);
    send_packet(pkt, 1'b0);
    build_packet(4'd2, 17, FILL_RANDOM, pkt);
    send_packet(pkt, 1'b1);
    build_packet(4'd0, 16, FILL_ZERO, pkt);
    send_packet(pkt, 1'b0);
    build_packet(4'd15, 37, FILL_ONES, pkt);
    send_packet(pkt, 1'b1);
    build_packet(4'd15, 39, FILL_RANDOM, pkt);
    send_packet(pkt, 1'b0);
    build_packet(4'd6, 20, FILL_RANDOM, pkt);
    cancel_udp_sum(pkt);
    send_packet(pkt, 1'b0);
    wait_for_results();

    while (words_sent < ITEM_TARGET || packets_sent < MIN_PACKETS) begin
      kind = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
      hw = header_span(ihl);
      if (kind < 12) begin
        n = $urandom_range(1, hw);
      end else if (kind < 16) begin
        n = hw + $urandom_range(100, 700);
      end else begin
        n = hw + $urandom_range(0, 24);
      end
      build_packet(4'(ihl), n, FILL_RANDOM, pkt);
      odd_tail = 1'($urandom_range(0, 1));
      if (kind >= 94 && n > hw) begin
        cancel_udp_sum(pkt);
        odd_tail = 1'b0;
      end
      send_packet(pkt, odd_tail);
      if ($urandom_range(0, 19) == 0) begin
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
